[hdl/scs_curve_number_runoff_defines.svh]
// Assertion macros for the curve-number runoff block.
// Expects clk_i and rst_ni in the scope where a macro is expanded.
`ifndef SCS_CURVE_NUMBER_RUNOFF_DEFINES_SVH
`define SCS_CURVE_NUMBER_RUNOFF_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/scs_pkg.sv]
// Shared constants, types and helpers of the curve-number runoff block.
// No dependencies; every other file but the defines header imports it.
package scs_pkg;

  localparam int unsigned RAIN_W      = 16;
  localparam int unsigned RATE_W      = 16;
  localparam int unsigned TOT_W       = 32;
  localparam int unsigned CN_W        = 15;
  localparam int unsigned COEFF_W     = 16;
  localparam int unsigned CN_FRAC     = 8;
  localparam int unsigned RET_NUM_W   = 15;
  localparam int unsigned RETENTION_NUM = 25400;
  localparam int unsigned RETENTION_OFS = 254;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [CN_W-1:0]    CN_RESET    = 15'd19200;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd13107;

  typedef enum logic {
    REG_CURVE_NUMBER = 1'b0,
    REG_ABSTR_COEFF  = 1'b1
  } cfg_reg_e;

  // Status of a bit-serial unit.
  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

  // Increase of a cumulative total, zero when it fell, saturated to the rate width.
  function automatic logic [RATE_W-1:0] rate_of(logic [TOT_W-1:0] now,
                                                logic [TOT_W-1:0] prior);
    logic [TOT_W-1:0] diff;
    diff = now - prior;
    if (now <= prior) begin
      rate_of = '0;
    end else if (diff > TOT_W'({RATE_W{1'b1}})) begin
      rate_of = '1;
    end else begin
      rate_of = diff[RATE_W-1:0];
    end
  endfunction

endpackage

[hdl/scs_item_if.sv]
// Input channel of the runoff block: one hourly rainfall word.
// Depends on scs_pkg.
interface scs_item_if import scs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RAIN_W-1:0] rain_depth;
  logic              series_start;

  modport source (output valid, output rain_depth, output series_start, input ready);
  modport sink   (input valid, input rain_depth, input series_start, output ready);
endinterface

[hdl/scs_result_if.sv]
// Output channel of the runoff block: hourly runoff and infiltration.
// Depends on scs_pkg.
interface scs_result_if import scs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] runoff_rate;
  logic [RATE_W-1:0] infiltration_rate;

  modport source (output valid, output runoff_rate, output infiltration_rate, input ready);
  modport sink   (input valid, input runoff_rate, input infiltration_rate, output ready);
endinterface

[hdl/scs_mul.sv]
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// Depends on scs_pkg.
module scs_mul import scs_pkg::*; #(
  parameter int unsigned A_W = 16,
  parameter int unsigned B_W = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output ser_stat_t          stat_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int unsigned CW = $clog2(A_W + 1);

  logic [A_W-1:0]     a_q, a_d;
  logic [B_W-1:0]     b_q, b_d;
  logic [A_W+B_W-1:0] acc_q, acc_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [B_W:0]       sum;

  always_comb begin
    sum    = {1'b0, acc_q[A_W+B_W-1:A_W]} + (a_q[0] ? {1'b0, b_q} : '0);
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d   = a_i;
      b_d   = b_i;
      acc_d = '0;
      cnt_d = CW'(A_W);
    end else if (cnt_q != '0) begin
      // add the partial product into the top and shift one place right
      acc_d  = {sum, acc_q[A_W-1:1]};
      a_d    = a_q >> 1;
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

[hdl/scs_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// The starting remainder must be below the divisor. Depends on scs_pkg.
module scs_div import scs_pkg::*; #(
  parameter int unsigned N_W = 32,
  parameter int unsigned D_W = 33
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [D_W-1:0] rem_i,
  input  logic [N_W-1:0] dvd_i,
  input  logic [D_W-1:0] dvs_i,
  output ser_stat_t      stat_o,
  output logic [N_W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(N_W + 1);

  logic [D_W-1:0] rem_q, rem_d;
  logic [D_W-1:0] dvs_q, dvs_d;
  logic [N_W-1:0] sh_q, sh_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           done_q, done_d;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           take;

  always_comb begin
    trial  = {rem_q, sh_q[N_W-1]};
    diff   = trial - {1'b0, dvs_q};
    take   = (trial >= {1'b0, dvs_q});
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = rem_i;
      dvs_d = dvs_i;
      sh_d  = dvd_i;
      cnt_d = CW'(N_W);
    end else if (cnt_q != '0) begin
      // dividend bits leave at the top while quotient bits enter at the bottom
      rem_d  = take ? diff[D_W-1:0] : trial[D_W-1:0];
      sh_d   = {sh_q[N_W-2:0], take};
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    sh_q  <= sh_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quot_o      = sh_q;

endmodule

[hdl/scs_curve_number_runoff.sv]
// Top level of the SCS curve-number runoff block.
// Depends on scs_pkg, scs_item_if, scs_result_if, scs_mul, scs_div and the defines header.
//
//  port       dir  handshake          word
//  item_i     in   valid/ready        rain_depth (Q8.8 mm), series_start
//  result_o   out  valid/ready        runoff_rate, infiltration_rate (Q8.8 mm)
//  APB        in   psel/penable/pwrite  0x0 curve_number, 0x4 abstraction_coeff
//
// Once a word is accepted, no further word is taken until it has been through
// a 32-step bit-serial square of P-Ia followed by a 32-step bit-serial divide.
// After reset and after every register write, retention S and abstraction Ia are
// rebuilt by a serial divide and a 16-step serial multiply; item_i.ready stays low
// meanwhile.
// A finished result waits in the output register; a new word is still taken.
`include "scs_curve_number_runoff_defines.svh"

module scs_curve_number_runoff import scs_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  scs_item_if.sink           item_i,
  scs_result_if.source       result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // width of the retention quotient and of S, Ia, S-Ia
  localparam int unsigned NW = RET_NUM_W + CN_FRAC + FRAC_BITS;
  // width of the runoff denominator P + S - Ia
  localparam int unsigned DW = ((NW > TOT_W) ? NW : TOT_W) + 1;
  localparam logic [NW-1:0] RetNum = NW'(RETENTION_NUM) << (CN_FRAC + FRAC_BITS);
  localparam logic [NW-1:0] RetOfs = NW'(RETENTION_OFS) << FRAC_BITS;

  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_SDIV  = 8'b0000_0010,
    ST_IAMUL = 8'b0000_0100,
    ST_IDLE  = 8'b0000_1000,
    ST_PREP  = 8'b0001_0000,
    ST_SQ    = 8'b0010_0000,
    ST_QDIV  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   dirty_q, dirty_d;

  // configuration
  logic [CN_W-1:0]    cn_q;
  logic [COEFF_W-1:0] coeff_q;
  logic               cfg_we;

  // cumulative state
  logic [TOT_W-1:0] p_q, p_d;
  logic [TOT_W-1:0] prevq_q, prevq_d;
  logic [TOT_W-1:0] prevf_q, prevf_d;

  // derived from configuration
  logic [NW-1:0] s_q, s_d;
  logic [NW-1:0] ia_q, ia_d;
  logic [NW-1:0] sr_q, sr_d;

  // per-word operands
  logic [TOT_W-1:0] d_q, d_d;
  logic [DW-1:0]    den_q, den_d;
  logic             zero_q, zero_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [RATE_W-1:0] runoff_q, runoff_d;
  logic [RATE_W-1:0] infil_q, infil_d;

  // serial units
  logic                   sdiv_start, ia_start, sq_start, qdiv_start;
  ser_stat_t              s_stat, ia_stat, sq_stat, q_stat;
  logic [NW-1:0]          s_quot;
  logic [COEFF_W+NW-1:0]  ia_prod;
  logic [2*TOT_W-1:0]     sq_prod;
  logic [TOT_W-1:0]       q_quot;
  logic [CN_W-1:0]        cn_div;

  // combinational helpers
  logic               accept;
  logic [NW-1:0]      s_new;
  logic [NW-1:0]      ia_new;
  logic [TOT_W-1:0]   p_base;
  logic [TOT_W:0]     p_sum;
  logic               ge;
  logic [TOT_W-1:0]   d_new;
  logic [DW-1:0]      den_new;
  logic [TOT_W-1:0]   qt;
  logic [TOT_W-1:0]   ft;

  // APB: always ready, write on the access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (cfg_reg_e'(paddr[2]) == REG_ABSTR_COEFF) ? PDATA_W'(coeff_q)
                                                             : PDATA_W'(cn_q);

  assign item_i.ready = (state_q == ST_IDLE) && !dirty_q && !cfg_we;
  assign accept       = item_i.valid && item_i.ready;

  // a zero curve number divides as the smallest nonzero one
  assign cn_div = (cn_q == '0) ? CN_W'(1) : cn_q;

  scs_div #(.N_W(NW), .D_W(CN_W)) u_s_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sdiv_start),
    .rem_i   ('0),
    .dvd_i   (RetNum),
    .dvs_i   (cn_div),
    .stat_o  (s_stat),
    .quot_o  (s_quot)
  );

  // clamp S at zero for curve numbers above 100
  assign s_new = (s_quot > RetOfs) ? (s_quot - RetOfs) : '0;

  scs_mul #(.A_W(COEFF_W), .B_W(NW)) u_ia_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ia_start),
    .a_i     (coeff_q),
    .b_i     (s_new),
    .stat_o  (ia_stat),
    .prod_o  (ia_prod)
  );

  assign ia_new = ia_prod[COEFF_W+NW-1:COEFF_W];

  // runoff terms from the registered P and the derived S, Ia
  assign ge      = (DW'(p_q) >= DW'(ia_q));
  assign d_new   = ge ? (p_q - TOT_W'(ia_q)) : '0;
  assign den_new = DW'(p_q) + DW'(sr_q);

  scs_mul #(.A_W(TOT_W), .B_W(TOT_W)) u_sq_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .a_i     (d_new),
    .b_i     (d_new),
    .stat_o  (sq_stat),
    .prod_o  (sq_prod)
  );

  // quotient fits 32 bits since den >= d, so the upper half seeds the remainder
  scs_div #(.N_W(TOT_W), .D_W(DW)) u_q_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (qdiv_start),
    .rem_i   (DW'(sq_prod[2*TOT_W-1:TOT_W])),
    .dvd_i   (sq_prod[TOT_W-1:0]),
    .dvs_i   (den_q),
    .stat_o  (q_stat),
    .quot_o  (q_quot)
  );

  assign qt = zero_q ? '0 : q_quot;
  assign ft = d_q - qt;

  // saturating cumulative rain; a series start drops the old total
  assign p_base = item_i.series_start ? '0 : p_q;
  assign p_sum  = {1'b0, p_base} + {1'b0, TOT_W'(item_i.rain_depth)};

  always_comb begin
    state_d     = state_q;
    dirty_d     = dirty_q || cfg_we;
    sdiv_start  = 1'b0;
    ia_start    = 1'b0;
    sq_start    = 1'b0;
    qdiv_start  = 1'b0;
    p_d         = p_q;
    prevq_d     = prevq_q;
    prevf_d     = prevf_q;
    s_d         = s_q;
    ia_d        = ia_q;
    sr_d        = sr_q;
    d_d         = d_q;
    den_d       = den_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && !result_o.ready;
    runoff_d    = runoff_q;
    infil_d     = infil_q;

    case (state_q)
      ST_INIT: begin
        // rebuild S and Ia from the current registers
        sdiv_start = 1'b1;
        dirty_d    = cfg_we;
        state_d    = ST_SDIV;
      end
      ST_SDIV: begin
        if (s_stat.done) begin
          s_d      = s_new;
          ia_start = 1'b1;
          state_d  = ST_IAMUL;
        end
      end
      ST_IAMUL: begin
        if (ia_stat.done) begin
          ia_d    = ia_new;
          sr_d    = s_q - ia_new;
          state_d = (dirty_q || cfg_we) ? ST_INIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (dirty_q) begin
          state_d = ST_INIT;
        end else if (accept) begin
          p_d = p_sum[TOT_W] ? '1 : p_sum[TOT_W-1:0];
          if (item_i.series_start) begin
            prevq_d = '0;
            prevf_d = '0;
          end
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        // below Ia the word yields no runoff; a zero denominator also forces zero
        d_d      = d_new;
        den_d    = den_new;
        zero_d   = !ge || (den_new == '0);
        sq_start = 1'b1;
        state_d  = ST_SQ;
      end
      ST_SQ: begin
        if (sq_stat.done) begin
          qdiv_start = 1'b1;
          state_d    = ST_QDIV;
        end
      end
      ST_QDIV: begin
        if (q_stat.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          runoff_d    = rate_of(qt, prevq_q);
          infil_d     = rate_of(ft, prevf_q);
          prevq_d     = qt;
          prevf_d     = ft;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      dirty_q     <= 1'b0;
      cn_q        <= CN_RESET;
      coeff_q     <= COEFF_RESET;
      p_q         <= '0;
      prevq_q     <= '0;
      prevf_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dirty_q     <= dirty_d;
      p_q         <= p_d;
      prevq_q     <= prevq_d;
      prevf_q     <= prevf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        case (cfg_reg_e'(paddr[2]))
          REG_CURVE_NUMBER: cn_q    <= pwdata[CN_W-1:0];
          REG_ABSTR_COEFF:  coeff_q <= pwdata[COEFF_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q      <= s_d;
    ia_q     <= ia_d;
    sr_q     <= sr_d;
    d_q      <= d_d;
    den_q    <= den_d;
    zero_q   <= zero_d;
    runoff_q <= runoff_d;
    infil_q  <= infil_d;
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.runoff_rate       = runoff_q;
  assign result_o.infiltration_rate = infil_q;

  `SCS_ASSERT_NXT(a_one_word_at_a_time, accept, !item_i.ready, "word taken while one in flight")
  `SCS_ASSERT_IMP(a_ia_within_s, state_q == ST_IDLE, ia_q <= s_q, "Ia exceeds S")
  `SCS_ASSERT_IMP(a_q_within_d, (state_q == ST_FIN) && !zero_q, q_quot <= d_q, "Q exceeds P-Ia")
  `SCS_ASSERT_NXT(a_write_marks_dirty, cfg_we, dirty_q, "register write not marked for rebuild")
  `SCS_ASSERT_IMP(a_units_quiet_idle, state_q == ST_IDLE, !(sq_stat.busy || q_stat.busy), "serial unit busy while idle")

endmodule
